[sv/vty_pkg.sv]
package vty_pkg;

  // Field widths of the request and result channels
  localparam int COMP_BITS    = 16;
  localparam int ANGLE_BITS   = 16;
  // The larger scaled operand sits in [2^30, 2^31); datapath widths follow from that
  localparam int NORM_TOP     = 30;
  localparam int SHIFT_BITS   = 5;
  localparam int SCALED_BITS  = 33;
  localparam int ROOT_BITS    = 32;
  localparam int SQ_BITS      = 2 * ROOT_BITS;
  localparam int REM_BITS     = ROOT_BITS + 4;
  localparam int CORDIC_BITS  = 36;
  localparam int ACC_BITS     = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int ROUND_SHIFT  = ACC_BITS - ANGLE_BITS;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] vec_x;
    logic signed [COMP_BITS-1:0] vec_y;
    logic signed [COMP_BITS-1:0] vec_z;
  } vec_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic                         zero_vector;
  } ang_t;

  typedef struct packed {
    logic zero;    // all components zero
    logic yaw_ok;  // horizontal projection non-zero
  } flags_t;

  // Travels alongside the square root
  typedef struct packed {
    logic signed [SCALED_BITS-1:0] yaw_a;
    logic signed [SCALED_BITS-1:0] yaw_b;
    logic signed [SCALED_BITS-1:0] pit_z;
    flags_t                        flags;
  } side_t;

  // Angle result of the vectoring pipe
  typedef struct packed {
    logic [ACC_BITS-1:0] yaw_acc;
    logic [ACC_BITS-1:0] pit_acc;
    flags_t              flags;
  } acc_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [ACC_BITS-1:0] atan_entry(input int i);
    logic [ACC_BITS-1:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Index of the highest set bit (0 for zero)
  function automatic logic [SHIFT_BITS-1:0] msb_pos(input logic [COMP_BITS-1:0] m);
    logic [SHIFT_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < COMP_BITS; i++) begin
      if (m[i]) r = SHIFT_BITS'(i);
    end
    return r;
  endfunction

  // Round half up from the accumulator to the output angle width
  function automatic logic [ANGLE_BITS-1:0] round_acc(input logic [ACC_BITS-1:0] acc);
    logic [ACC_BITS-1:0] s;
    s = acc + (ACC_BITS'(1) << (ROUND_SHIFT - 1));
    return s[ACC_BITS-1 -: ANGLE_BITS];
  endfunction

endpackage

[sv/vector_to_yaw_pitch.sv]
// Direction vector to yaw and pitch.
// Request channel vec_valid / vec_ready carries vec (x, y, z, signed).
// Result channel ang_valid / ang_ready carries ang: yaw = atan2(y, x),
// pitch = -atan2(z, |(x, y)|), both with 2^15 units per pi, and a flag
// for the all-zero vector (pitch then 0; yaw is 0 whenever x = y = 0).
// A request is taken in every cycle the pipe can move, so throughput is
// one vector per clock. There are 68 register stages:
// 4 stages of scaling and squaring, 32 stages of the bit-per-stage square
// root, 31 stages of the CORDIC vectoring pipe and one output register.
// The whole pipe advances together: when a result sits unaccepted in the
// output register, every stage holds and vec_ready falls, so nothing is
// lost or repeated; empty slots hold too and are not squeezed out.
// Synchronous reset clears all valid bits; the data registers are not
// reset. No state is kept between vectors.
module vector_to_yaw_pitch (
  input  logic          clk,
  input  logic          rst,
  input  logic          vec_valid,
  output logic          vec_ready,
  input  vty_pkg::vec_t vec,
  output logic          ang_valid,
  input  logic          ang_ready,
  output vty_pkg::ang_t ang
);

  logic                          en;
  logic                          sq_valid, rt_valid, cd_valid;
  logic [vty_pkg::SQ_BITS-1:0]   sum_sq;
  logic [vty_pkg::ROOT_BITS-1:0] root;
  vty_pkg::side_t                sq_side, rt_side;
  vty_pkg::acc_t                 acc;

  // Global advance: output slot empty or being taken
  assign en        = !ang_valid || ang_ready;
  assign vec_ready = en;

  vty_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vec_valid),
    .vec      (vec),
    .valid    (sq_valid),
    .sum_sq   (sum_sq),
    .side     (sq_side)
  );

  vty_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sq_valid),
    .sum_sq   (sum_sq),
    .in_side  (sq_side),
    .valid    (rt_valid),
    .root     (root),
    .side     (rt_side)
  );

  vty_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (rt_valid),
    .root     (root),
    .side     (rt_side),
    .valid    (cd_valid),
    .acc      (acc)
  );

  // Output register: rounding and special cases
  always_ff @(posedge clk) begin
    if (rst) begin
      ang_valid <= 1'b0;
    end else if (en) begin
      ang_valid <= cd_valid;
    end
    if (en) begin
      ang.yaw_angle   <= acc.flags.yaw_ok ? signed'(vty_pkg::round_acc(acc.yaw_acc)) : '0;
      ang.pitch_angle <= acc.flags.zero ? '0
                         : signed'(vty_pkg::round_acc(vty_pkg::ACC_BITS'(0) - acc.pit_acc));
      ang.zero_vector <= acc.flags.zero;
    end
  end

endmodule

[sv/vty_prep.sv]
module vty_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  vty_pkg::vec_t                 vec,
  output logic                          valid,
  output logic [vty_pkg::SQ_BITS-1:0]   sum_sq,
  output vty_pkg::side_t                side
);

  localparam int CB = vty_pkg::COMP_BITS;
  localparam int SB = vty_pkg::SCALED_BITS;
  localparam int RB = vty_pkg::ROOT_BITS;
  localparam int HB = vty_pkg::SHIFT_BITS;

  // Stage 1: magnitudes, maxima and normalising shifts
  logic                 v1;
  logic signed [CB-1:0] x1, y1, z1;
  logic [CB-1:0]        mx1, my1;
  logic [HB-1:0]        sh_yaw1, sh_pit1;
  vty_pkg::flags_t      fl1;

  logic [CB-1:0] mx_c, my_c, mz_c, mxy_c, mall_c;

  always_comb begin
    mx_c   = vec.vec_x[CB-1] ? CB'(-vec.vec_x) : CB'(vec.vec_x);
    my_c   = vec.vec_y[CB-1] ? CB'(-vec.vec_y) : CB'(vec.vec_y);
    mz_c   = vec.vec_z[CB-1] ? CB'(-vec.vec_z) : CB'(vec.vec_z);
    mxy_c  = (mx_c > my_c) ? mx_c : my_c;
    mall_c = (mxy_c > mz_c) ? mxy_c : mz_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      x1          <= vec.vec_x;
      y1          <= vec.vec_y;
      z1          <= vec.vec_z;
      mx1         <= mx_c;
      my1         <= my_c;
      sh_yaw1     <= HB'(vty_pkg::NORM_TOP) - vty_pkg::msb_pos(mxy_c);
      sh_pit1     <= HB'(vty_pkg::NORM_TOP) - vty_pkg::msb_pos(mall_c);
      fl1.zero    <= (mall_c == '0);
      fl1.yaw_ok  <= (mxy_c != '0);
    end
  end

  // Stage 2: scale operands
  logic          v2;
  logic [RB-1:0] ax2, ay2;
  vty_pkg::side_t side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      side2.yaw_a <= SB'(x1) <<< sh_yaw1;
      side2.yaw_b <= SB'(y1) <<< sh_yaw1;
      side2.pit_z <= SB'(z1) <<< sh_pit1;
      side2.flags <= fl1;
      ax2         <= RB'(mx1) << sh_pit1;
      ay2         <= RB'(my1) << sh_pit1;
    end
  end

  // Stage 3: squares
  logic                       v3;
  logic [vty_pkg::SQ_BITS-1:0] sqx3, sqy3;
  vty_pkg::side_t              side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      sqx3  <= ax2 * ax2;
      sqy3  <= ay2 * ay2;
      side3 <= side2;
    end
  end

  // Stage 4: sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v3;
    end
    if (en) begin
      sum_sq <= sqx3 + sqy3;
      side   <= side3;
    end
  end

endmodule

[sv/vty_isqrt.sv]
module vty_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [vty_pkg::SQ_BITS-1:0]   sum_sq,
  input  vty_pkg::side_t                in_side,
  output logic                          valid,
  output logic [vty_pkg::ROOT_BITS-1:0] root,
  output vty_pkg::side_t                side
);

  localparam int RB = vty_pkg::ROOT_BITS;
  localparam int MB = vty_pkg::REM_BITS;
  localparam int QB = vty_pkg::SQ_BITS;

  // One root bit per stage, most significant first
  logic [MB-1:0]  rm [1:RB];
  logic [RB-1:0]  rt [1:RB];
  logic [QB-1:0]  nn [1:RB];
  vty_pkg::side_t sd [1:RB];
  logic           vd [1:RB];

  for (genvar j = 0; j < RB; j++) begin : g_stage
    localparam int BI = RB - 1 - j;
    logic [MB-1:0]  rem_sh, trial;
    logic [MB-1:0]  rm_in;
    logic [RB-1:0]  rt_in;
    logic [QB-1:0]  nn_in;
    vty_pkg::side_t sd_in;
    logic           vd_in;

    // First stage takes the request straight from the ports
    if (j == 0) begin : g_first
      assign rm_in = '0;
      assign rt_in = '0;
      assign nn_in = sum_sq;
      assign sd_in = in_side;
      assign vd_in = in_valid;
    end else begin : g_next
      assign rm_in = rm[j];
      assign rt_in = rt[j];
      assign nn_in = nn[j];
      assign sd_in = sd[j];
      assign vd_in = vd[j];
    end

    always_comb begin
      rem_sh = {rm_in[MB-3:0], nn_in[2*BI+1 -: 2]};
      trial  = {2'b00, rt_in, 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[j+1] <= 1'b0;
      end else if (en) begin
        vd[j+1] <= vd_in;
      end
      if (en) begin
        nn[j+1] <= nn_in;
        sd[j+1] <= sd_in;
        if (rem_sh >= trial) begin
          rm[j+1] <= rem_sh - trial;
          rt[j+1] <= {rt_in[RB-2:0], 1'b1};
        end else begin
          rm[j+1] <= rem_sh;
          rt[j+1] <= {rt_in[RB-2:0], 1'b0};
        end
      end
    end
  end

  assign valid = vd[RB];
  assign root  = rt[RB];
  assign side  = sd[RB];

endmodule

[sv/vty_cordic.sv]
module vty_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [vty_pkg::ROOT_BITS-1:0] root,
  input  vty_pkg::side_t                side,
  output logic                          valid,
  output vty_pkg::acc_t                 acc
);

  localparam int WB = vty_pkg::CORDIC_BITS;
  localparam int AB = vty_pkg::ACC_BITS;
  localparam int NS = vty_pkg::CORDIC_STEPS;

  // Two lanes: yaw on (x, y), pitch on (horizontal length, z)
  logic signed [WB-1:0] ya [0:NS];
  logic signed [WB-1:0] yb [0:NS];
  logic signed [WB-1:0] pa [0:NS];
  logic signed [WB-1:0] pb [0:NS];
  logic [AB-1:0]        yc [0:NS];
  logic [AB-1:0]        pc [0:NS];
  vty_pkg::flags_t      fl [0:NS];
  logic                 vd [0:NS];

  logic signed [WB-1:0] ya_c, yb_c, pa_c, pb_c;

  // Entry stage: fold the left half-plane onto the right
  always_comb begin
    ya_c = WB'(side.yaw_a);
    yb_c = WB'(side.yaw_b);
    pa_c = WB'(signed'({1'b0, root}));
    pb_c = WB'(side.pit_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (en) begin
      vd[0] <= in_valid;
    end
    if (en) begin
      fl[0] <= side.flags;
      if (ya_c < 0) begin
        ya[0] <= -ya_c;
        yb[0] <= -yb_c;
        yc[0] <= {1'b1, {(AB-1){1'b0}}};
      end else begin
        ya[0] <= ya_c;
        yb[0] <= yb_c;
        yc[0] <= '0;
      end
      if (pa_c < 0) begin
        pa[0] <= -pa_c;
        pb[0] <= -pb_c;
        pc[0] <= {1'b1, {(AB-1){1'b0}}};
      end else begin
        pa[0] <= pa_c;
        pb[0] <= pb_c;
        pc[0] <= '0;
      end
    end
  end

  // Micro-rotations, one per stage
  for (genvar i = 0; i < NS; i++) begin : g_rot
    localparam logic [AB-1:0] ANG = vty_pkg::atan_entry(i);

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[i+1] <= 1'b0;
      end else if (en) begin
        vd[i+1] <= vd[i];
      end
      if (en) begin
        fl[i+1] <= fl[i];
        if (!yb[i][WB-1]) begin
          ya[i+1] <= ya[i] + (yb[i] >>> i);
          yb[i+1] <= yb[i] - (ya[i] >>> i);
          yc[i+1] <= yc[i] + ANG;
        end else begin
          ya[i+1] <= ya[i] - (yb[i] >>> i);
          yb[i+1] <= yb[i] + (ya[i] >>> i);
          yc[i+1] <= yc[i] - ANG;
        end
        if (!pb[i][WB-1]) begin
          pa[i+1] <= pa[i] + (pb[i] >>> i);
          pb[i+1] <= pb[i] - (pa[i] >>> i);
          pc[i+1] <= pc[i] + ANG;
        end else begin
          pa[i+1] <= pa[i] - (pb[i] >>> i);
          pb[i+1] <= pb[i] + (pa[i] >>> i);
          pc[i+1] <= pc[i] - ANG;
        end
      end
    end
  end

  assign valid       = vd[NS];
  assign acc.yaw_acc = yc[NS];
  assign acc.pit_acc = pc[NS];
  assign acc.flags   = fl[NS];

endmodule

[sim/tb_vector_to_yaw_pitch.sv]
`timescale 1ns / 100ps

module tb_vector_to_yaw_pitch;

  localparam int LATENCY     = 68;
  localparam int WATCHDOG    = 20000;
  localparam int N_RANDOM    = 500;
  localparam int QUIET_TAIL  = 60;

  // atan(2^-i), 2^32 units per turn
  localparam logic [31:0] ATAN_LUT [30] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vec_valid = 1'b0;
  logic vec_ready;
  vty_pkg::vec_t vec = '0;
  logic ang_valid;
  logic ang_ready = 1'b0;
  vty_pkg::ang_t ang;

  vty_pkg::ang_t angle_fifo[$];
  int   n_errors = 0;
  int   idle_cycles = 0;
  bit   no_stall = 1'b0;
  bit   sending = 1'b1;

  // directed stimulus; expected result given only where it is obvious
  typedef struct {
    logic signed [15:0] x, y, z;
    bit   has_exp;
    vty_pkg::ang_t exp;
  } dir_row_t;

  vector_to_yaw_pitch dut (
    .clk(clk), .rst(rst), .vec_valid(vec_valid), .vec_ready(vec_ready),
    .vec(vec), .ang_valid(ang_valid), .ang_ready(ang_ready), .ang(ang));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---- predictor ----
  function automatic int unsigned norm_bits(longint unsigned m);
    int unsigned s;
    s = 0;
    if (m == 0) return 0;
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      s++;
    end
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] cordic_angle(longint a, longint b);
    logic [31:0] acc;
    longint da, db;
    acc = '0;
    if (a < 0) begin
      a = -a;
      b = -b;
      acc = 32'h8000_0000;
    end
    for (int i = 0; i < 30; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a = a + da;
        b = b - db;
        acc = acc + ATAN_LUT[i];
      end else begin
        a = a - da;
        b = b + db;
        acc = acc - ATAN_LUT[i];
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] round_angle(logic [31:0] acc);
    logic [31:0] s;
    s = acc + 32'h0000_8000;
    return s[31:16];
  endfunction

  function automatic vty_pkg::ang_t predict_angles(vty_pkg::vec_t v);
    longint x, y, z, f;
    longint unsigned mx, my, mz, mxy, mall, ax, ay;
    logic [31:0] yaw_acc, pitch_acc;
    vty_pkg::ang_t r;
    x = v.vec_x;
    y = v.vec_y;
    z = v.vec_z;
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    mz = (z < 0) ? -z : z;
    mxy = (mx > my) ? mx : my;
    mall = (mxy > mz) ? mxy : mz;
    yaw_acc = '0;
    pitch_acc = '0;
    if (mxy != 0) begin
      f = 64'sd1 << norm_bits(mxy);
      yaw_acc = cordic_angle(x * f, y * f);
    end
    if (mall != 0) begin
      f = 64'sd1 << norm_bits(mall);
      ax = (x < 0) ? -(x * f) : x * f;
      ay = (y < 0) ? -(y * f) : y * f;
      pitch_acc = 32'd0 - cordic_angle(longint'(int_sqrt(ax * ax + ay * ay)), z * f);
    end
    r.yaw_angle = round_angle(yaw_acc);
    r.pitch_angle = round_angle(pitch_acc);
    r.zero_vector = (mall == 0);
    return r;
  endfunction

  // ---- result checking ----
  always @(posedge clk) begin
    if (!rst && ang_valid && ang_ready) begin
      if (angle_fifo.size() == 0) begin
        $error("result with nothing expected: yaw %0d pitch %0d",
               ang.yaw_angle, ang.pitch_angle);
        n_errors++;
      end else begin
        vty_pkg::ang_t e;
        e = angle_fifo.pop_front();
        if (ang.yaw_angle !== e.yaw_angle) begin
          $error("yaw_angle expected %0d got %0d", e.yaw_angle, ang.yaw_angle);
          n_errors++;
        end
        if (ang.pitch_angle !== e.pitch_angle) begin
          $error("pitch_angle expected %0d got %0d", e.pitch_angle, ang.pitch_angle);
          n_errors++;
        end
        if (ang.zero_vector !== e.zero_vector) begin
          $error("zero_vector expected %0b got %0b", e.zero_vector, ang.zero_vector);
          n_errors++;
        end
      end
    end
  end

  // ---- result side stall bursts ----
  initial begin : result_stall
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (no_stall || $urandom_range(0, 2) != 0) begin
        ang_ready <= 1'b1;
        n = $urandom_range(1, 30);
      end else begin
        ang_ready <= 1'b0;
        n = $urandom_range(1, 19);
      end
      repeat (n) @(posedge clk);
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if ((vec_valid && vec_ready) || (ang_valid && ang_ready) || rst)
      idle_cycles <= 0;
    else if (sending || angle_fifo.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---- request driving ----
  task automatic send_vector(vty_pkg::vec_t v, bit pause_ok);
    if (pause_ok && $urandom_range(0, 5) == 0) begin
      vec_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    vec_valid <= 1'b1;
    vec <= v;
    @(posedge clk);
    while (!vec_ready) @(posedge clk);
    angle_fifo.push_back(predict_angles(v));
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      3: return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    dir_row_t rows[$];
    dir_row_t row;
    vty_pkg::vec_t v;
    vty_pkg::ang_t e;
    // zero vector: flag set, both angles zero
    rows.push_back('{0, 0, 0, 1, '{16'sd0, 16'sd0, 1'b1}});
    // straight ahead along x
    rows.push_back('{16'sh7fff, 0, 0, 1, '{16'sd0, 16'sd0, 1'b0}});
    // along +y: yaw pi/2
    rows.push_back('{0, 16'sh7fff, 0, 1, '{16'sd16384, 16'sd0, 1'b0}});
    // along -y: yaw -pi/2
    rows.push_back('{0, 16'sh8000, 0, 1, '{-16'sd16384, 16'sd0, 1'b0}});
    // straight back wraps to the most negative code
    rows.push_back('{16'sh8000, 0, 0, 1, '{16'sh8000, 16'sd0, 1'b0}});
    rows.push_back('{-16'sd1, 0, 0, 1, '{16'sh8000, 16'sd0, 1'b0}});
    // vertical up and down: yaw 0, pitch -+pi/2
    rows.push_back('{0, 0, 16'sh7fff, 1, '{16'sd0, -16'sd16384, 1'b0}});
    rows.push_back('{0, 0, 16'sh8000, 1, '{16'sd0, 16'sd16384, 1'b0}});
    rows.push_back('{0, 0, 16'sd1, 1, '{16'sd0, -16'sd16384, 1'b0}});
    rows.push_back('{0, 0, -16'sd1, 1, '{16'sd0, 16'sd16384, 1'b0}});
    // predictor rows: extremes and diagonals
    rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 0, '0});
    rows.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 0, '0});
    rows.push_back('{16'sh8000, 16'sh7fff, 16'sh8000, 0, '0});
    rows.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 0, '0});
    rows.push_back('{16'sd1, 16'sd1, 16'sd1, 0, '0});
    rows.push_back('{-16'sd1, 16'sd1, -16'sd1, 0, '0});
    rows.push_back('{16'sd1, 16'sh8000, 16'sd0, 0, '0});
    rows.push_back('{16'sh5555, -16'sh2aaa, 16'sh0f0f, 0, '0});
    rows.push_back('{-16'sd3, -16'sd4, 16'sd5, 0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      v.vec_x = row.x;
      v.vec_y = row.y;
      v.vec_z = row.z;
      if (row.has_exp) begin
        e = predict_angles(v);
        if (e !== row.exp) begin
          $error("table row %0d: predictor disagrees with typed result", i);
          n_errors++;
        end
      end
      send_vector(v, 1'b1);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // hold off until the pipe drains, once mid-run
      if (n == N_RANDOM / 2) begin
        vec_valid <= 1'b0;
        wait (angle_fifo.size() == 0);
        @(posedge clk);
      end
      if (n == N_RANDOM - QUIET_TAIL) no_stall = 1'b1;
      v.vec_x = rand_comp();
      v.vec_y = rand_comp();
      v.vec_z = rand_comp();
      send_vector(v, !no_stall);
    end
    vec_valid <= 1'b0;
    sending = 1'b0;

    wait (angle_fifo.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0 && angle_fifo.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
